// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the two-operand ALU.
// Clocked, reset-qualified property checks; compiled out under ASSERT_OFF.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that the consequent holds whenever the antecedent does
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/topalu_pkg.sv =====
// Package for the two-operand ALU: operation codes, result kinds, stage types
// and the one-bit restoring division step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package topalu_pkg;

  localparam int unsigned WORD_W = 16;

  // Operation codes
  localparam logic [3:0] MODE_JE  = 4'd0;
  localparam logic [3:0] MODE_JL  = 4'd1;
  localparam logic [3:0] MODE_JG  = 4'd2;
  localparam logic [3:0] MODE_DEC = 4'd3;
  localparam logic [3:0] MODE_INC = 4'd4;
  localparam logic [3:0] MODE_TST = 4'd5;
  localparam logic [3:0] MODE_OR  = 4'd6;
  localparam logic [3:0] MODE_AND = 4'd7;
  localparam logic [3:0] MODE_ADD = 4'd8;
  localparam logic [3:0] MODE_SUB = 4'd9;
  localparam logic [3:0] MODE_MUL = 4'd10;
  localparam logic [3:0] MODE_DIV = 4'd11;
  localparam logic [3:0] MODE_MOD = 4'd12;

  // Result kinds
  localparam logic [1:0] KIND_COND  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_VAR   = 2'd2;

  // Division is spread over DIV_STG stages of DIV_BITS quotient bits each
  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV_STG  = WORD_W / DIV_BITS;
  // input register, prepare stage, division stages, output register
  localparam int unsigned NUM_STG  = DIV_STG + 3;

  typedef struct packed {
    logic [3:0]        mode;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic [WORD_W-1:0] operand_c;
    logic [WORD_W-1:0] operand_d;
    logic [3:0]        operand_present;
    logic [WORD_W-1:0] variable_value;
  } raw_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [WORD_W-1:0] value;
    logic              cond;
    logic [1:0]        kind;
    logic              dbz;
    logic [WORD_W-1:0] quo;   // dividend bits shift out, quotient bits shift in
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dsr;
    logic              neg_q;
    logic              neg_r;
  } work_t;

  typedef struct packed {
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
  } div_t;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  // The partial remainder stays below the divisor, so the shifted value fits.
  function automatic div_t div_step(logic [WORD_W-1:0] quo, logic [WORD_W-1:0] rem,
                                    logic [WORD_W-1:0] dsr);
    div_t          r;
    logic [WORD_W:0] sh;
    logic [WORD_W:0] df;
    sh    = {rem, quo[WORD_W-1]};
    df    = sh - {1'b0, dsr};
    r.quo = {quo[WORD_W-2:0], ~df[WORD_W]};
    r.rem = df[WORD_W] ? sh[WORD_W-1:0] : df[WORD_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/two_operand_alu_and_branch_test_unit.sv =====
// Two-operand ALU and branch test unit: 16-bit compare, logic, arithmetic,
// multiply and pipelined signed divide. Depends on topalu_pkg, assert_macros.svh.
//
// Usage:
//   The in_ channel carries one instruction per item (operation code, four
//   operand words, presence mask, variable value); the out_ channel returns
//   exactly one item per instruction, in order: result word, branch condition
//   and divide-by-zero flag in out_tdata, result kind in out_tuser.
//   Items pass through seven register stages: input register, operand
//   preparation (all non-divide results and the multiply are done here), four
//   division stages of four quotient bits each, output register.
//   Throughput is one item per cycle unless the receiver stalls; the four-bit
//   division stages set the depth. Each stage holds a valid bit and advances
//   when the stage after it is empty or moving, so bubbles close up under stall
//   and in_tready stays high while any stage is free, even with a result waiting
//   at the output. When the receiver stalls, every item is held in place;
//   nothing is lost or repeated. Synchronous active-low reset empties all
//   stages; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module two_operand_alu_and_branch_test_unit
  import topalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] mode, [19:4] operand_a, [35:20] operand_b, [51:36] operand_c,
  // [67:52] operand_d, [71:68] operand_present, [87:72] variable_value
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] result_value, [16] condition, [17] divide_by_zero, [23:18] zero
  output logic [23:0]      out_tdata,
  // [1:0] result_kind
  output logic [1:0]       out_tuser
);

  logic [NUM_STG-1:0] v_r;
  logic [NUM_STG-1:0] rdy;

  raw_t              raw_r;
  raw_t              raw_nxt;
  work_t             prep_nxt;
  work_t             wk_r   [0:DIV_STG];
  work_t             wk_nxt [1:DIV_STG];

  logic [WORD_W-1:0] out_value_r;
  logic              out_cond_r;
  logic [1:0]        out_kind_r;
  logic              out_dbz_r;
  logic [WORD_W-1:0] out_value_nxt;

  // Stage readiness: a stage may load when empty or when its item moves on
  always_comb begin
    rdy[NUM_STG-1] = !v_r[NUM_STG-1] || out_tready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_tready = rdy[0];

  always_comb begin
    raw_nxt.mode            = in_tdata[3:0];
    raw_nxt.operand_a       = in_tdata[19:4];
    raw_nxt.operand_b       = in_tdata[35:20];
    raw_nxt.operand_c       = in_tdata[51:36];
    raw_nxt.operand_d       = in_tdata[67:52];
    raw_nxt.operand_present = in_tdata[71:68];
    raw_nxt.variable_value  = in_tdata[87:72];
  end

  // Prepare stage: finish every non-divide operation, set up the divider
  always_comb begin
    logic [WORD_W-1:0]   x;
    logic [WORD_W-1:0]   nv;
    logic [2*WORD_W-1:0] prod;
    prep_nxt       = '0;
    prep_nxt.mode  = raw_r.mode;
    x    = raw_r.operand_present[0] ? raw_r.operand_a : '0;
    nv   = '0;
    prod = raw_r.operand_a * raw_r.operand_b;
    prep_nxt.quo   = raw_r.operand_a[WORD_W-1] ? (~raw_r.operand_a + 1'b1)
                                               : raw_r.operand_a;
    prep_nxt.dsr   = raw_r.operand_b[WORD_W-1] ? (~raw_r.operand_b + 1'b1)
                                               : raw_r.operand_b;
    prep_nxt.neg_q = raw_r.operand_a[WORD_W-1] ^ raw_r.operand_b[WORD_W-1];
    prep_nxt.neg_r = raw_r.operand_a[WORD_W-1];
    case (raw_r.mode)
      MODE_JE: begin
        prep_nxt.cond = (raw_r.operand_present[1] && raw_r.operand_b == x) ||
                        (raw_r.operand_present[2] && raw_r.operand_c == x) ||
                        (raw_r.operand_present[3] && raw_r.operand_d == x);
      end
      MODE_JL: begin
        prep_nxt.cond = $signed(raw_r.operand_a) < $signed(raw_r.operand_b);
      end
      MODE_JG: begin
        prep_nxt.cond = $signed(raw_r.operand_a) > $signed(raw_r.operand_b);
      end
      MODE_DEC: begin
        nv             = raw_r.variable_value - 1'b1;
        prep_nxt.value = nv;
        prep_nxt.cond  = $signed(nv) < $signed(raw_r.operand_b);
        prep_nxt.kind  = KIND_VAR;
      end
      MODE_INC: begin
        nv             = raw_r.variable_value + 1'b1;
        prep_nxt.value = nv;
        prep_nxt.cond  = $signed(nv) > $signed(raw_r.operand_b);
        prep_nxt.kind  = KIND_VAR;
      end
      MODE_TST: begin
        prep_nxt.cond = (raw_r.operand_a & raw_r.operand_b) == raw_r.operand_b;
      end
      MODE_OR: begin
        prep_nxt.value = raw_r.operand_a | raw_r.operand_b;
        prep_nxt.kind  = KIND_STORE;
      end
      MODE_AND: begin
        prep_nxt.value = raw_r.operand_a & raw_r.operand_b;
        prep_nxt.kind  = KIND_STORE;
      end
      MODE_ADD: begin
        prep_nxt.value = raw_r.operand_a + raw_r.operand_b;
        prep_nxt.kind  = KIND_STORE;
      end
      MODE_SUB: begin
        prep_nxt.value = raw_r.operand_a - raw_r.operand_b;
        prep_nxt.kind  = KIND_STORE;
      end
      MODE_MUL: begin
        prep_nxt.value = prod[WORD_W-1:0];
        prep_nxt.kind  = KIND_STORE;
      end
      MODE_DIV, MODE_MOD: begin
        prep_nxt.kind = KIND_STORE;
        prep_nxt.dbz  = (raw_r.operand_b == '0);
      end
      default: begin
        prep_nxt.kind = KIND_COND;
      end
    endcase
  end

  // Division stages: DIV_BITS restoring steps each on magnitudes
  always_comb begin
    div_t ds;
    ds = '0;
    for (int k = 1; k <= DIV_STG; k++) begin
      wk_nxt[k] = wk_r[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        ds            = div_step(wk_nxt[k].quo, wk_nxt[k].rem, wk_nxt[k].dsr);
        wk_nxt[k].quo = ds.quo;
        wk_nxt[k].rem = ds.rem;
      end
    end
  end

  // Output stage: restore signs and pick the result word
  always_comb begin
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] r;
    q = wk_r[DIV_STG].neg_q ? (~wk_r[DIV_STG].quo + 1'b1) : wk_r[DIV_STG].quo;
    r = wk_r[DIV_STG].neg_r ? (~wk_r[DIV_STG].rem + 1'b1) : wk_r[DIV_STG].rem;
    out_value_nxt = wk_r[DIV_STG].value;
    if (!wk_r[DIV_STG].dbz) begin
      if (wk_r[DIV_STG].mode == MODE_DIV) begin
        out_value_nxt = q;
      end else if (wk_r[DIV_STG].mode == MODE_MOD) begin
        out_value_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_tvalid) begin
      raw_r <= raw_nxt;
    end
    if (rdy[1] && v_r[0]) begin
      wk_r[0] <= prep_nxt;
    end
    for (int k = 1; k <= DIV_STG; k++) begin
      if (rdy[k+1] && v_r[k]) begin
        wk_r[k] <= wk_nxt[k];
      end
    end
    // hold the result until taken
    if (rdy[NUM_STG-1] && v_r[NUM_STG-2]) begin
      out_value_r <= out_value_nxt;
      out_cond_r  <= wk_r[DIV_STG].cond;
      out_kind_r  <= wk_r[DIV_STG].kind;
      out_dbz_r   <= wk_r[DIV_STG].dbz;
    end
  end

  assign out_tvalid = v_r[NUM_STG-1];
  assign out_tdata  = {6'd0, out_dbz_r, out_cond_r, out_value_r};
  assign out_tuser  = out_kind_r;

  `ASSERT_NEXT(a_fill_one, clk, rst_n,
               in_tvalid && in_tready && !(out_tvalid && out_tready),
               $countones(v_r) == $countones($past(v_r)) + 1)
  `ASSERT_NEXT(a_drain_one, clk, rst_n,
               !(in_tvalid && in_tready) && out_tvalid && out_tready,
               $countones(v_r) + 1 == $countones($past(v_r)))
  `ASSERT_IMPL(a_dbz_store, clk, rst_n, out_tvalid && out_tdata[17],
               out_tuser == KIND_STORE && out_tdata[15:0] == '0)
  `ASSERT_IMPL(a_cond_kind, clk, rst_n, out_tvalid && out_tdata[16],
               out_tuser != KIND_STORE)
  `ASSERT_IMPL(a_cond_only_zero, clk, rst_n, out_tvalid && out_tuser == KIND_COND,
               out_tdata[15:0] == '0 && !out_tdata[17])

endmodule

`default_nettype wire

// ===== tb/two_operand_alu_and_branch_test_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-operand ALU and branch test unit: directed corner
// items, then a random mix under sender bursts and receiver stalls.
// Depends on topalu_pkg and two_operand_alu_and_branch_test_unit.

module two_operand_alu_and_branch_test_unit_tb;
  import topalu_pkg::*;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          RANDOM_ITEMS    = 1850;
  localparam int          DRAIN_CYCLES    = 16;
  localparam logic [3:0]  MODE_FIRST_FREE = MODE_MOD + 4'd1;
  localparam logic [3:0]  MODE_LAST_CODE  = 4'hF;

  // in_tdata layout, highest field first
  typedef struct packed {
    logic [15:0] variable_value;
    logic [3:0]  operand_present;
    logic [15:0] operand_d;
    logic [15:0] operand_c;
    logic [15:0] operand_b;
    logic [15:0] operand_a;
    logic [3:0]  mode;
  } alu_instr_t;

  // out_tdata layout, highest field first
  typedef struct packed {
    logic [5:0]  pad;
    logic        dbz;
    logic        cond;
    logic [15:0] value;
  } result_word_t;

  typedef struct {
    result_word_t word;
    logic [1:0]   kind;
    logic [3:0]   mode;
  } alu_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  alu_outcome_t pending_results[$];
  int           mismatch_count = 0;
  int           checked_count  = 0;
  int           accepted_count = 0;
  int           dbz_count      = 0;
  int           taken_count    = 0;
  int           mode_seen[16];
  int           cycle_count    = 0;
  int           burst_left     = 0;

  two_operand_alu_and_branch_test_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic alu_outcome_t predict_alu_result(alu_instr_t i);
    alu_outcome_t r;
    int           sa;
    int           sb;
    int           q;
    logic [15:0]  lhs;
    r.word = '0;
    r.kind = KIND_COND;
    r.mode = i.mode;
    sa = int'($signed(i.operand_a));
    sb = int'($signed(i.operand_b));
    case (i.mode)
      MODE_JE: begin
        lhs = i.operand_present[0] ? i.operand_a : 16'd0;
        r.word.cond = (i.operand_present[1] && i.operand_b == lhs) ||
                      (i.operand_present[2] && i.operand_c == lhs) ||
                      (i.operand_present[3] && i.operand_d == lhs);
      end
      MODE_JL:  r.word.cond = (sa < sb);
      MODE_JG:  r.word.cond = (sa > sb);
      MODE_DEC: begin
        r.word.value = i.variable_value - 16'd1;
        r.word.cond  = ($signed(r.word.value) < $signed(i.operand_b));
        r.kind       = KIND_VAR;
      end
      MODE_INC: begin
        r.word.value = i.variable_value + 16'd1;
        r.word.cond  = ($signed(r.word.value) > $signed(i.operand_b));
        r.kind       = KIND_VAR;
      end
      MODE_TST: r.word.cond = ((i.operand_a & i.operand_b) == i.operand_b);
      MODE_OR: begin
        r.word.value = i.operand_a | i.operand_b;
        r.kind       = KIND_STORE;
      end
      MODE_AND: begin
        r.word.value = i.operand_a & i.operand_b;
        r.kind       = KIND_STORE;
      end
      MODE_ADD: begin
        r.word.value = i.operand_a + i.operand_b;
        r.kind       = KIND_STORE;
      end
      MODE_SUB: begin
        r.word.value = i.operand_a - i.operand_b;
        r.kind       = KIND_STORE;
      end
      MODE_MUL: begin
        r.word.value = i.operand_a * i.operand_b;
        r.kind       = KIND_STORE;
      end
      MODE_DIV, MODE_MOD: begin
        r.kind = KIND_STORE;
        if (i.operand_b == 16'd0) begin
          r.word.dbz = 1'b1;
        end else begin
          // int arithmetic truncates toward zero; -32768 / -1 lands on 0x8000
          q = (i.mode == MODE_DIV) ? sa / sb : sa % sb;
          r.word.value = q[15:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic alu_instr_t build_instr(logic [3:0] mode, logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, logic [15:0] d,
                                             logic [3:0] pres, logic [15:0] var_value);
    alu_instr_t i;
    i.mode            = mode;
    i.operand_a       = a;
    i.operand_b       = b;
    i.operand_c       = c;
    i.operand_d       = d;
    i.operand_present = pres;
    i.variable_value  = var_value;
    return i;
  endfunction

  // Bias towards the signed extremes and small magnitudes
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    case ($urandom_range(0, 9))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      2:       w = 16'h8000;
      3:       w = 16'h7FFF;
      4:       w = 16'h0001;
      5:       w = 16'($urandom_range(0, 15));
      6:       w = -16'($urandom_range(1, 16));
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string field, int got, int want, logic [3:0] mode);
    $display("mismatch: result %0d (mode %0d) %s got 0x%0h expected 0x%0h",
             checked_count, mode, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_instr(alu_instr_t instr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    in_tdata  <= instr;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Cycle count, timeout and the receiver's stall pattern
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
    case (cycle_count[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= ($urandom_range(0, 2) == 0);
      default: out_tready <= cycle_count[3];
    endcase
  end

  // Predict on each accepted item, check each accepted result against the oldest
  always @(posedge clk) begin
    alu_instr_t   instr;
    alu_outcome_t want;
    result_word_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        instr = alu_instr_t'(in_tdata);
        pending_results.push_back(predict_alu_result(instr));
        mode_seen[instr.mode]++;
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        got = result_word_t'(out_tdata);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, value", got.value, 0, 4'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.word.value)
            report_mismatch("result_value", got.value, want.word.value, want.mode);
          if (got.cond !== want.word.cond)
            report_mismatch("condition", got.cond, want.word.cond, want.mode);
          if (got.dbz !== want.word.dbz)
            report_mismatch("divide_by_zero", got.dbz, want.word.dbz, want.mode);
          if (got.pad !== want.word.pad)
            report_mismatch("tdata padding", got.pad, want.word.pad, want.mode);
          if (out_tuser !== want.kind)
            report_mismatch("result_kind", out_tuser, want.kind, want.mode);
          if (want.word.dbz) dbz_count++;
          if (want.word.cond) taken_count++;
        end
        checked_count++;
      end
    end
  end

  task automatic test_equality_presence();
    // nothing present among b, c, d: never taken
    send_instr(build_instr(MODE_JE, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 4'b0001, 16'hFFFF));
    // absent a compares as zero
    send_instr(build_instr(MODE_JE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 4'b1110, 16'h0000));
    send_instr(build_instr(MODE_JE, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 4'b0011, 16'h5A5A));
    send_instr(build_instr(MODE_JE, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0001, 4'b0101, 16'hA5A5));
    send_instr(build_instr(MODE_JE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 4'b1001, 16'h8000));
    // present operands that all differ
    send_instr(build_instr(MODE_JE, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 4'b1111, 16'h7FFF));
  endtask

  task automatic test_signed_compares();
    send_instr(build_instr(MODE_JL, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 4'hF, 16'h0000));
    send_instr(build_instr(MODE_JG, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 4'h0, 16'hFFFF));
    send_instr(build_instr(MODE_JL, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 4'h3, 16'h0001));
    // variable wraps downwards and upwards across the sign boundary
    send_instr(build_instr(MODE_DEC, 16'h0010, 16'h0000, 16'hFFFF, 16'hFFFF, 4'hA, 16'h0000));
    send_instr(build_instr(MODE_INC, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 4'h5, 16'h7FFF));
    send_instr(build_instr(MODE_INC, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 4'h0, 16'hFFFF));
    send_instr(build_instr(MODE_TST, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 4'hF, 16'h1234));
    send_instr(build_instr(MODE_TST, 16'h0F0F, 16'h0F1F, 16'h0000, 16'h0000, 4'h0, 16'h0000));
  endtask

  task automatic test_store_ops();
    send_instr(build_instr(MODE_OR,  16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF));
    send_instr(build_instr(MODE_AND, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_ADD, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_SUB, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_MUL, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 4'h0, 16'h0000));
  endtask

  task automatic test_divide_edges();
    send_instr(build_instr(MODE_DIV, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_MOD, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 4'hF, 16'hFFFF));
    send_instr(build_instr(MODE_DIV, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_MOD, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_DIV, -16'd7, 16'd2, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    send_instr(build_instr(MODE_MOD, -16'd7, 16'd2, 16'h0000, 16'h0000, 4'h0, 16'h0000));
    // unused codes return all zeros
    send_instr(build_instr(MODE_FIRST_FREE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 4'hF,
                           16'hFFFF));
    send_instr(build_instr(MODE_LAST_CODE, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 4'h1,
                           16'h0000));
  endtask

  task automatic test_random_mix(int count);
    alu_instr_t  instr;
    logic [15:0] lhs;
    for (int n = 0; n < count; n++) begin
      instr = build_instr(4'd0, pick_word(), pick_word(), pick_word(), pick_word(),
                          4'($urandom_range(0, 15)), pick_word());
      if ($urandom_range(0, 19) == 0)
        instr.mode = 4'($urandom_range(MODE_FIRST_FREE, MODE_LAST_CODE));
      else
        instr.mode = 4'($urandom_range(MODE_JE, MODE_MOD));
      case (instr.mode)
        MODE_JE: begin
          // plant a match in one slot half the time
          lhs = instr.operand_present[0] ? instr.operand_a : 16'd0;
          case ($urandom_range(0, 5))
            0:       instr.operand_b = lhs;
            1:       instr.operand_c = lhs;
            2:       instr.operand_d = lhs;
            default: ;
          endcase
        end
        MODE_DEC, MODE_INC: begin
          if ($urandom_range(0, 1))
            instr.operand_b = instr.variable_value + 16'($urandom_range(0, 4)) - 16'd2;
        end
        MODE_TST: begin
          if ($urandom_range(0, 1)) instr.operand_b = instr.operand_a & 16'($urandom);
        end
        MODE_DIV, MODE_MOD: begin
          if ($urandom_range(0, 2) == 0)
            instr.operand_b = 16'($urandom_range(0, 8)) - 16'd4;
        end
        default: ;
      endcase
      send_instr(instr);
    end
  endtask

  initial begin
    int modes_hit;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_equality_presence();
    test_signed_compares();
    test_store_ops();
    test_divide_edges();
    test_random_mix(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    modes_hit = 0;
    foreach (mode_seen[m]) if (mode_seen[m] != 0) modes_hit++;
    $display("covered %0d instructions across %0d of 16 operation codes, %0d results checked",
             accepted_count, modes_hit, checked_count);
    $display("branch taken %0d times, divide-by-zero flagged %0d times, %0d mismatches",
             taken_count, dbz_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
